>>> sv/wdwr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wdwr_pkg;

    // Fixed field widths of the transactions
    localparam int CMD_BITS        = 3;
    localparam int INDEX_BITS      = 6;
    localparam int LOAD_BITS       = 32;
    localparam int TOTAL_BITS      = 38;
    localparam int OUT_WEIGHT_BITS = 31;
    localparam int STATUS_BITS     = 2;

    localparam logic [TOTAL_BITS-1:0]      TOTAL_MAX      = '1;
    localparam logic [OUT_WEIGHT_BITS-1:0] OUT_WEIGHT_MAX = '1;

    // Command codes
    localparam logic [CMD_BITS-1:0] CMD_LOAD        = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_DRAW        = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_RESTORE_ALL = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_RESTORE     = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE      = 3'd4;

    // Status codes
    localparam logic [STATUS_BITS-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_BITS-1:0] STAT_RANGE = 2'd2;

    typedef struct packed {
        logic [CMD_BITS-1:0]          command;
        logic [INDEX_BITS-1:0]        entry_index;
        logic signed [LOAD_BITS-1:0]  load_weight;
        logic [TOTAL_BITS-1:0]        draw_value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0]     status;
        logic [INDEX_BITS-1:0]      drawn_index;
        logic [OUT_WEIGHT_BITS-1:0] drawn_weight;
        logic [TOTAL_BITS-1:0]      remaining_total;
    } out_item_t;

    // Write controls from the sequencer to the weight table
    typedef struct packed {
        logic we_weight;
        logic we_active;
        logic active_val;
    } tbl_ctl_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LD_SUB_FULL,
        S_LD_ADD_FULL,
        S_LD_SUB_REM,
        S_LD_ADD_REM,
        S_DR_CHECK,
        S_DR_WALK,
        S_DR_TAKE,
        S_RESTORE_ALL,
        S_ENTRY_UPD,
        S_DONE
    } seq_state_t;

    // Width of the exact totals: enough for every entry at full weight
    function automatic int sum_width(input int entries, input int weight_bits);
        int raw;
        begin
            raw = weight_bits + $clog2(entries) + 1;
            return (raw > TOTAL_BITS) ? raw : TOTAL_BITS;
        end
    endfunction

endpackage

`default_nettype wire

>>> sv/weighted_draw_without_replacement_unit.sv
// Weighted draw without replacement.
// Request channel (req_valid / req_stall / req_data) carries one command per
// transaction: load weight, draw, restore all, restore entry, remove entry.
// Response channel (rsp_valid / rsp_stall / rsp_data) returns exactly one
// result per command: status, drawn entry and weight, remaining total.
// Commands are handled one at a time by a sequencer around a single shared
// adder/subtractor and a one-read, one-write weight table.
// Steps per command: load takes the old weight from the full total and
// adds the new one, then does the same for the remaining total; restore
// and remove entry update the remaining total at most once; a draw checks
// for an empty table and range, then walks one stored entry per cycle
// through the adder and clears the chosen entry; restore all writes one
// active bit per cycle. A new request is taken the cycle after the result
// enters the output register. After reset the table is swept to zero; req_stall
// stays high meanwhile. The output register frees the sequencer: while the
// receiver stalls, one further command may be accepted and processed, and
// its result waits in the sequencer until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module weighted_draw_without_replacement_unit #(
    parameter int ENTRIES     = 64,
    parameter int WEIGHT_BITS = 31
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      req_valid,
    output logic                     req_stall,
    input  wire wdwr_pkg::in_item_t  req_data,
    output logic                     rsp_valid,
    input  wire                      rsp_stall,
    output wdwr_pkg::out_item_t      rsp_data
);

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int SUM_W = wdwr_pkg::sum_width(ENTRIES, WEIGHT_BITS);

    wdwr_pkg::tbl_ctl_t      tbl_ctl;
    logic [IDX_W-1:0]        wr_addr, rd_addr;
    logic [WEIGHT_BITS-1:0]  wr_weight, rd_weight;
    logic                    rd_active;

    logic                               res_valid, out_free;
    logic [wdwr_pkg::STATUS_BITS-1:0]   res_status;
    logic [IDX_W-1:0]                   res_index;
    logic [WEIGHT_BITS-1:0]             res_weight;
    logic [SUM_W-1:0]                   res_total;

    logic                 rsp_valid_reg, rsp_valid_next;
    wdwr_pkg::out_item_t  rsp_data_reg, rsp_data_next;

    wdwr_table #(
        .ENTRIES     (ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_table (
        .clk       (clk),
        .ctl       (tbl_ctl),
        .wr_addr   (wr_addr),
        .wr_weight (wr_weight),
        .rd_addr   (rd_addr),
        .rd_weight (rd_weight),
        .rd_active (rd_active)
    );

    wdwr_seq #(
        .ENTRIES     (ENTRIES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .tbl_ctl    (tbl_ctl),
        .wr_addr    (wr_addr),
        .wr_weight  (wr_weight),
        .rd_addr    (rd_addr),
        .rd_weight  (rd_weight),
        .rd_active  (rd_active),
        .res_valid  (res_valid),
        .out_free   (out_free),
        .res_status (res_status),
        .res_index  (res_index),
        .res_weight (res_weight),
        .res_total  (res_total)
    );

    assign out_free = !rsp_valid_reg || !rsp_stall;

    // Format and saturate the result fields
    always_comb
    begin
        rsp_data_next.status      = res_status;
        rsp_data_next.drawn_index = wdwr_pkg::INDEX_BITS'(res_index);
        rsp_data_next.drawn_weight =
            (64'(res_weight) > 64'(wdwr_pkg::OUT_WEIGHT_MAX))
                ? wdwr_pkg::OUT_WEIGHT_MAX
                : wdwr_pkg::OUT_WEIGHT_BITS'(res_weight);
        rsp_data_next.remaining_total =
            (res_total > SUM_W'(wdwr_pkg::TOTAL_MAX))
                ? wdwr_pkg::TOTAL_MAX
                : res_total[wdwr_pkg::TOTAL_BITS-1:0];
    end

    // Output register valid
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_free)
        begin
            rsp_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && res_valid)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

endmodule

`default_nettype wire

>>> sv/wdwr_table.sv
`timescale 1ns / 1ps
`default_nettype none

module wdwr_table #(
    parameter int ENTRIES     = 64,
    parameter int WEIGHT_BITS = 31,
    localparam int IDX_W      = $clog2(ENTRIES)
) (
    input  wire                      clk,
    input  wire wdwr_pkg::tbl_ctl_t  ctl,
    input  wire [IDX_W-1:0]          wr_addr,
    input  wire [WEIGHT_BITS-1:0]    wr_weight,
    input  wire [IDX_W-1:0]          rd_addr,
    output logic [WEIGHT_BITS-1:0]   rd_weight,
    output logic                     rd_active
);

    logic [WEIGHT_BITS-1:0] weight_mem [ENTRIES];
    logic                   active_mem [ENTRIES];

    // Write port
    always_ff @(posedge clk)
    begin
        if (ctl.we_weight)
        begin
            weight_mem[wr_addr] <= wr_weight;
        end
        if (ctl.we_active)
        begin
            active_mem[wr_addr] <= ctl.active_val;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_weight <= weight_mem[rd_addr];
        rd_active <= active_mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> sv/wdwr_addsub.sv
`timescale 1ns / 1ps
`default_nettype none

module wdwr_addsub #(
    parameter int W = 38
) (
    input  wire [W-1:0]  a,
    input  wire [W-1:0]  b,
    input  wire          sub,
    output logic [W-1:0] sum,
    output logic         carry
);

    logic [W-1:0] b_inv;

    // a + b, or a - b as a + ~b + 1; on subtract, carry set means a >= b
    assign b_inv = sub ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_inv} + (W + 1)'(sub);

endmodule

`default_nettype wire

>>> sv/wdwr_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module wdwr_seq #(
    parameter int ENTRIES     = 64,
    parameter int WEIGHT_BITS = 31,
    localparam int IDX_W      = $clog2(ENTRIES),
    localparam int SUM_W      = wdwr_pkg::sum_width(ENTRIES, WEIGHT_BITS)
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    // request side
    input  wire                                  req_valid,
    output logic                                 req_stall,
    input  wire wdwr_pkg::in_item_t              req_data,
    // table port
    output wdwr_pkg::tbl_ctl_t                   tbl_ctl,
    output logic [IDX_W-1:0]                     wr_addr,
    output logic [WEIGHT_BITS-1:0]               wr_weight,
    output logic [IDX_W-1:0]                     rd_addr,
    input  wire [WEIGHT_BITS-1:0]                rd_weight,
    input  wire                                  rd_active,
    // result towards the output register
    output logic                                 res_valid,
    input  wire                                  out_free,
    output logic [wdwr_pkg::STATUS_BITS-1:0]     res_status,
    output logic [IDX_W-1:0]                     res_index,
    output logic [WEIGHT_BITS-1:0]               res_weight,
    output logic [SUM_W-1:0]                     res_total
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [63:0]      WMAX64   = (64'd1 << WEIGHT_BITS) - 64'd1;

    wdwr_pkg::seq_state_t state_reg, state_next;

    logic [wdwr_pkg::CMD_BITS-1:0]    cmd_reg, cmd_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [WEIGHT_BITS-1:0]           wt_reg, wt_next;
    logic [wdwr_pkg::TOTAL_BITS-1:0]  val_reg, val_next;
    logic [IDX_W-1:0]                 walk_reg, walk_next;
    logic [SUM_W-1:0]                 run_reg, run_next;
    logic [SUM_W-1:0]                 full_reg, full_next;
    logic [SUM_W-1:0]                 rem_reg, rem_next;
    logic [wdwr_pkg::STATUS_BITS-1:0] status_reg, status_next;
    logic [IDX_W-1:0]                 pick_idx_reg, pick_idx_next;
    logic [WEIGHT_BITS-1:0]           pick_w_reg, pick_w_next;

    logic [SUM_W-1:0] op_a, op_b, op_sum;
    logic             op_sub, op_carry;
    logic             in_range;

    // Negative loads become zero, oversize loads saturate
    function automatic logic [WEIGHT_BITS-1:0] clamp_weight(input logic [31:0] raw);
        logic [63:0] pos;
        begin
            pos = raw[31] ? 64'd0 : {32'd0, raw};
            return (pos > WMAX64) ? WMAX64[WEIGHT_BITS-1:0] : pos[WEIGHT_BITS-1:0];
        end
    endfunction

    // Shared adder / subtractor
    wdwr_addsub #(
        .W (SUM_W)
    ) u_addsub (
        .a     (op_a),
        .b     (op_b),
        .sub   (op_sub),
        .sum   (op_sum),
        .carry (op_carry)
    );

    assign in_range = 32'(req_data.entry_index) < 32'(ENTRIES);

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wdwr_pkg::S_CLEAR;
            walk_reg  <= '0;
            full_reg  <= '0;
            rem_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            full_reg  <= full_next;
            rem_reg   <= rem_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        idx_reg      <= idx_next;
        wt_reg       <= wt_next;
        val_reg      <= val_next;
        run_reg      <= run_next;
        status_reg   <= status_next;
        pick_idx_reg <= pick_idx_next;
        pick_w_reg   <= pick_w_next;
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        idx_next      = idx_reg;
        wt_next       = wt_reg;
        val_next      = val_reg;
        walk_next     = walk_reg;
        run_next      = run_reg;
        full_next     = full_reg;
        rem_next      = rem_reg;
        status_next   = status_reg;
        pick_idx_next = pick_idx_reg;
        pick_w_next   = pick_w_reg;

        op_a      = rem_reg;
        op_b      = '0;
        op_sub    = 1'b0;
        rd_addr   = idx_reg;
        wr_addr   = idx_reg;
        wr_weight = wt_reg;
        tbl_ctl   = '0;
        req_stall = 1'b1;
        res_valid = 1'b0;

        case (state_reg)
            // sweep zeros through the table after reset
            wdwr_pkg::S_CLEAR:
            begin
                tbl_ctl.we_weight  = 1'b1;
                tbl_ctl.we_active  = 1'b1;
                tbl_ctl.active_val = 1'b0;
                wr_addr   = walk_reg;
                wr_weight = '0;
                walk_next = walk_reg + IDX_W'(1);
                if (walk_reg == LAST_IDX)
                begin
                    walk_next  = '0;
                    state_next = wdwr_pkg::S_IDLE;
                end
            end

            wdwr_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                rd_addr   = IDX_W'(req_data.entry_index);
                if (req_valid)
                begin
                    cmd_next      = req_data.command;
                    idx_next      = IDX_W'(req_data.entry_index);
                    wt_next       = clamp_weight(req_data.load_weight);
                    val_next      = req_data.draw_value;
                    walk_next     = '0;
                    run_next      = '0;
                    status_next   = wdwr_pkg::STAT_OK;
                    pick_idx_next = '0;
                    pick_w_next   = '0;
                    case (req_data.command)
                        wdwr_pkg::CMD_LOAD:
                            state_next = in_range ? wdwr_pkg::S_LD_SUB_FULL
                                                  : wdwr_pkg::S_DONE;
                        wdwr_pkg::CMD_DRAW:
                            state_next = wdwr_pkg::S_DR_CHECK;
                        wdwr_pkg::CMD_RESTORE_ALL:
                            state_next = wdwr_pkg::S_RESTORE_ALL;
                        wdwr_pkg::CMD_RESTORE,
                        wdwr_pkg::CMD_REMOVE:
                            state_next = in_range ? wdwr_pkg::S_ENTRY_UPD
                                                  : wdwr_pkg::S_DONE;
                        default:
                            state_next = wdwr_pkg::S_DONE;
                    endcase
                end
            end

            // load: drop old weight from full total
            wdwr_pkg::S_LD_SUB_FULL:
            begin
                op_a       = full_reg;
                op_b       = SUM_W'(rd_weight);
                op_sub     = 1'b1;
                full_next  = op_sum;
                state_next = wdwr_pkg::S_LD_ADD_FULL;
            end

            wdwr_pkg::S_LD_ADD_FULL:
            begin
                op_a       = full_reg;
                op_b       = SUM_W'(wt_reg);
                full_next  = op_sum;
                state_next = wdwr_pkg::S_LD_SUB_REM;
            end

            // old weight leaves the remaining sum only if it was active
            wdwr_pkg::S_LD_SUB_REM:
            begin
                op_a       = rem_reg;
                op_b       = rd_active ? SUM_W'(rd_weight) : '0;
                op_sub     = 1'b1;
                rem_next   = op_sum;
                state_next = wdwr_pkg::S_LD_ADD_REM;
            end

            wdwr_pkg::S_LD_ADD_REM:
            begin
                op_a               = rem_reg;
                op_b               = SUM_W'(wt_reg);
                rem_next           = op_sum;
                tbl_ctl.we_weight  = 1'b1;
                tbl_ctl.we_active  = 1'b1;
                tbl_ctl.active_val = 1'b1;
                state_next         = wdwr_pkg::S_DONE;
            end

            // draw: empty and range checks, prefetch entry 0
            wdwr_pkg::S_DR_CHECK:
            begin
                rd_addr = '0;
                op_a    = SUM_W'(val_reg);
                op_b    = rem_reg;
                op_sub  = 1'b1;
                if (rem_reg == '0)
                begin
                    status_next = wdwr_pkg::STAT_EMPTY;
                    state_next  = wdwr_pkg::S_DONE;
                end
                else if (op_carry)
                begin
                    status_next = wdwr_pkg::STAT_RANGE;
                    state_next  = wdwr_pkg::S_DONE;
                end
                else
                begin
                    state_next = wdwr_pkg::S_DR_WALK;
                end
            end

            // one entry per cycle; next entry is read meanwhile
            wdwr_pkg::S_DR_WALK:
            begin
                rd_addr  = walk_reg + IDX_W'(1);
                op_a     = run_reg;
                op_b     = rd_active ? SUM_W'(rd_weight) : '0;
                run_next = op_sum;
                if (rd_active && (op_sum > SUM_W'(val_reg)))
                begin
                    pick_idx_next = walk_reg;
                    pick_w_next   = rd_weight;
                    state_next    = wdwr_pkg::S_DR_TAKE;
                end
                else if (walk_reg == LAST_IDX)
                begin
                    state_next = wdwr_pkg::S_DONE;
                end
                else
                begin
                    walk_next = walk_reg + IDX_W'(1);
                end
            end

            wdwr_pkg::S_DR_TAKE:
            begin
                wr_addr            = pick_idx_reg;
                tbl_ctl.we_active  = 1'b1;
                tbl_ctl.active_val = 1'b0;
                op_a               = rem_reg;
                op_b               = SUM_W'(pick_w_reg);
                op_sub             = 1'b1;
                rem_next           = op_sum;
                state_next         = wdwr_pkg::S_DONE;
            end

            // sweep active bits on; remaining becomes full
            wdwr_pkg::S_RESTORE_ALL:
            begin
                wr_addr            = walk_reg;
                tbl_ctl.we_active  = 1'b1;
                tbl_ctl.active_val = 1'b1;
                rem_next           = full_reg;
                walk_next          = walk_reg + IDX_W'(1);
                if (walk_reg == LAST_IDX)
                begin
                    walk_next  = '0;
                    state_next = wdwr_pkg::S_DONE;
                end
            end

            // single entry restore or remove
            wdwr_pkg::S_ENTRY_UPD:
            begin
                op_a = rem_reg;
                op_b = SUM_W'(rd_weight);
                if (cmd_reg == wdwr_pkg::CMD_RESTORE)
                begin
                    if (!rd_active)
                    begin
                        tbl_ctl.we_active  = 1'b1;
                        tbl_ctl.active_val = 1'b1;
                        rem_next           = op_sum;
                    end
                end
                else
                begin
                    op_sub = 1'b1;
                    if (rd_active)
                    begin
                        tbl_ctl.we_active  = 1'b1;
                        tbl_ctl.active_val = 1'b0;
                        rem_next           = op_sum;
                    end
                end
                state_next = wdwr_pkg::S_DONE;
            end

            // hold the result until the output register takes it
            wdwr_pkg::S_DONE:
            begin
                res_valid = 1'b1;
                if (out_free)
                begin
                    state_next = wdwr_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = wdwr_pkg::S_IDLE;
            end
        endcase
    end

    assign res_status = status_reg;
    assign res_index  = pick_idx_reg;
    assign res_weight = pick_w_reg;
    assign res_total  = rem_reg;

endmodule

`default_nettype wire
